// File: hdl/amet_pkg.sv
// ----------------------------------------------------------------------------
// amet_pkg
// shared types, constants and helpers of the adjacency matrix edge table
// ----------------------------------------------------------------------------
package amet_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int WEIGHT_WIDTH = 16;

    localparam int VIDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int ADDR_W  = 2 * VIDX_W;
    localparam int DEPTH   = MAX_VERTICES * MAX_VERTICES;
    localparam int NSIZE_W = $clog2(MAX_VERTICES + 1);
    localparam int CNT_W   = (NSIZE_W > 5) ? NSIZE_W : 5;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_NO_EDGE      = 1'b1;

    localparam logic [4:0]  VERTEX_COUNT_RST = 5'd16;
    localparam logic [15:0] NO_EDGE_RST      = 16'h7fff;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         from_vertex;
        logic [3:0]         to_vertex;
        logic signed [15:0] weight;
    } t_amet_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] edge_total;
    } t_amet_out;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MOD   = 4'b0010,
        S_CLEAR = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    function automatic logic [WEIGHT_WIDTH-1:0] to_weight(input logic signed [15:0] raw);
        return WEIGHT_WIDTH'(raw);
    endfunction

endpackage

// File: hdl/amet_ram.sv
// ----------------------------------------------------------------------------
// amet_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module amet_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/adjacency_matrix_edge_table.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_edge_table
// insert and remove: the word is latched on start and checked in S_MOD, then
// the result strobe is registered; a new word may start in the cycle the result is shown
// clear: walks the n*n entries for n active vertices, one ram entry written a cycle
// result strobe lasts one cycle and cannot be held off by the receiver
// reset clears the counter and control state; matrix unusable until a clear
// ----------------------------------------------------------------------------
module adjacency_matrix_edge_table
    import amet_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_amet_in  i_cmd_word,
    output logic      o_valid,
    output t_amet_out o_res_word,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [4:0]              r_vertex_count;
    logic [15:0]             r_no_edge;
    logic [7:0]              r_count, n_count;
    logic [1:0]              r_cmd;
    logic [3:0]              r_u, r_v;
    logic [WEIGHT_WIDTH-1:0] r_w;
    logic [VIDX_W-1:0]       r_ci, n_ci, r_cj, n_cj;
    logic                    r_valid, n_valid;
    t_amet_out               r_res, n_res;

    logic                    accept;
    logic [CNT_W-1:0]        n_active;
    logic [WEIGHT_WIDTH-1:0] none;
    logic                    bad_idx;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [WEIGHT_WIDTH-1:0] mem_wdata, mem_rdata;
    logic                    last_j, last_i;

    amet_ram #(
        .WIDTH (WEIGHT_WIDTH),
        .DEPTH (DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign none      = to_weight(r_no_edge);
    assign n_active  = (CNT_W'(r_vertex_count) > CNT_W'(MAX_VERTICES)) ?
                       CNT_W'(MAX_VERTICES) : CNT_W'(r_vertex_count);
    assign mem_raddr = {VIDX_W'(i_cmd_word.from_vertex), VIDX_W'(i_cmd_word.to_vertex)};
    assign bad_idx   = (CNT_W'(r_u) >= n_active) || (CNT_W'(r_v) >= n_active) ||
                       (r_u == r_v);
    assign last_j    = (CNT_W'(r_cj) == n_active - CNT_W'(1));
    assign last_i    = (CNT_W'(r_ci) == n_active - CNT_W'(1));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ci      = r_ci;
        n_cj      = r_cj;
        n_valid   = 1'b0;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = {VIDX_W'(r_u), VIDX_W'(r_v)};
        mem_wdata = r_w;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd_word.command == CMD_CLEAR) begin
                        n_count = 8'd0;
                        n_ci    = '0;
                        n_cj    = '0;
                        n_state = (n_active == '0) ? S_DONE : S_CLEAR;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_state          = S_IDLE;
                n_valid          = 1'b1;
                n_res.status     = ST_OK;
                if ((r_cmd != CMD_INSERT && r_cmd != CMD_REMOVE) || bad_idx) begin
                    n_res.status = ST_BAD;
                end else if (r_cmd == CMD_INSERT) begin
                    if (mem_rdata != none) begin
                        n_res.status = ST_DUP;
                    end else begin
                        mem_we = 1'b1;
                        if (r_count != 8'hff) begin
                            n_count = r_count + 8'd1;
                        end
                    end
                end else begin
                    if (mem_rdata == none) begin
                        n_res.status = ST_ABSENT;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = none;
                        if (r_count != 8'd0) begin
                            n_count = r_count - 8'd1;
                        end
                    end
                end
                n_res.edge_total = n_count;
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_ci, r_cj};
                mem_wdata = (r_ci == r_cj) ? '0 : none;
                if (last_j) begin
                    n_cj = '0;
                    if (last_i) begin
                        n_state = S_DONE;
                    end else begin
                        n_ci = r_ci + VIDX_W'(1);
                    end
                end else begin
                    n_cj = r_cj + VIDX_W'(1);
                end
            end
            S_DONE: begin
                n_state          = S_IDLE;
                n_valid          = 1'b1;
                n_res.status     = ST_OK;
                n_res.edge_total = r_count;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= 8'd0;
            r_valid        <= 1'b0;
            r_vertex_count <= VERTEX_COUNT_RST;
            r_no_edge      <= NO_EDGE_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[4:0];
                    CFG_NO_EDGE:      r_no_edge      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ci  <= n_ci;
        r_cj  <= n_cj;
        r_res <= n_res;
        if (accept) begin
            r_cmd <= i_cmd_word.command;
            r_u   <= i_cmd_word.from_vertex;
            r_v   <= i_cmd_word.to_vertex;
            r_w   <= to_weight(i_cmd_word.weight);
        end
    end

    assign o_valid    = r_valid;
    assign o_res_word = r_res;

endmodule
